// File: rtl/c8_pkg.sv
`default_nettype none

package c8_pkg;

  localparam int unsigned MEM_BYTES    = 4096;
  localparam int unsigned SCR_PIXELS   = 2048;
  localparam int unsigned STACK_DEPTH  = 16;
  localparam logic [11:0] START_PC     = 12'h200;
  localparam int unsigned FONT_BYTES   = 80;
  localparam int unsigned SCREEN_COLS  = 64;

  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_KEY   = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_PIXEL = 2'd3
  } action_e;

  // instruction groups by top nibble
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] F_GETDT = 8'h07;
  localparam logic [7:0] F_WKEY  = 8'h0A;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD  = 8'h65;

  localparam logic [3:0] REG_FLAG = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  key_index;
    logic        key_pressed;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  random_byte;
    logic [10:0] pixel_index;
  } c8_in_t;

  typedef struct packed {
    logic [11:0] pc_value;
    logic [15:0] current_opcode;
    logic        draw_pending;
    logic        sound_on;
    logic        pixel_value;
    logic        bad_opcode;
    logic        waiting_key;
  } c8_out_t;

endpackage

`default_nettype wire

// File: rtl/c8_if.sv
`default_nettype none

interface c8_in_if;
  import c8_pkg::*;
  logic   valid;
  logic   ready;
  c8_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c8_out_if;
  import c8_pkg::*;
  logic    valid;
  logic    ready;
  c8_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/c8_ram.sv
`default_nettype none

module c8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/chip8_instruction_core.sv
`default_nettype none
// channel  | dir | payload   | accepted when
// in_i     | in  | c8_in_t   | in_i.valid & in_i.ready
// out_o    | out | c8_out_t  | out_o.valid & out_o.ready
//
// Key and memory-write items go straight to finishing; a pixel item reads the
// framebuffer first. An instruction reads two program bytes, then Vx and Vy,
// executes, and writes VF in an extra step for a flag. Draw reads each sprite
// row byte and checks its eight columns, flipping the pixel of each set bit;
// FX55/FX65 read and write per register, FX33 writes three digits; clear-screen
// clears one framebuffer word a cycle. After reset a pass over memory loads the
// font and zeroes memory, framebuffer and V registers; no item is taken meanwhile.
// A held result does not block taking the next item; only its finish waits.

module chip8_instruction_core #(
  parameter int unsigned MEMORY_BYTES  = c8_pkg::MEM_BYTES,
  parameter int unsigned SCREEN_PIXELS = c8_pkg::SCR_PIXELS,
  parameter int unsigned STACK_DEPTH   = c8_pkg::STACK_DEPTH
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  c8_in_if.sink    in_i,
  c8_out_if.source out_o
);
  import c8_pkg::*;

  localparam int unsigned AW  = $clog2(MEMORY_BYTES);
  localparam int unsigned PW  = $clog2(SCREEN_PIXELS);
  localparam int unsigned SPW = $clog2(STACK_DEPTH);

  typedef enum logic [20:0] {
    S_CLR     = 21'h000001,
    S_IDLE    = 21'h000002,
    S_PIX     = 21'h000004,
    S_FETCHHI = 21'h000008,
    S_FETCHLO = 21'h000010,
    S_DEC     = 21'h000020,
    S_RDX     = 21'h000040,
    S_RDY     = 21'h000080,
    S_EXEC    = 21'h000100,
    S_FLAG    = 21'h000200,
    S_FBCLR   = 21'h000400,
    S_BCD     = 21'h000800,
    S_STRD    = 21'h001000,
    S_STWR    = 21'h002000,
    S_LDRD    = 21'h004000,
    S_LDWR    = 21'h008000,
    S_DRMEM   = 21'h010000,
    S_DRBYTE  = 21'h020000,
    S_DRRD    = 21'h040000,
    S_DRWR    = 21'h080000,
    S_DONE    = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic [11:0]    pc_q, pc_d;
  logic [7:0]     ophi_q, ophi_d;
  logic [15:0]    op_q, op_d;
  logic [7:0]     vx_q, vx_d, vy_q, vy_d;
  logic [15:0]    i_q, i_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [11:0]    stack_q [STACK_DEPTH];
  logic [11:0]    stack_d [STACK_DEPTH];
  logic [15:0]    keys_q, keys_d;
  logic [7:0]     dt_q, dt_d, st_q, st_d;
  logic           dirty_q, dirty_d;
  logic [7:0]     rnd_q, rnd_d;
  logic           bad_q, bad_d, wait_q, wait_d, pix_q, pix_d, tick_q, tick_d;
  logic           flag_q, flag_d, hit_q, hit_d;
  logic [7:0]     bits_q, bits_d;
  logic [3:0]     row_q, row_d;
  logic [2:0]     col_q, col_d;
  logic           ovalid_q, ovalid_d;
  c8_out_t        odata_q, odata_d;

  // memory ports
  logic          pm_we;
  logic [AW-1:0] pm_wa, pm_ra;
  logic [7:0]    pm_wd, pm_rd;
  logic          fb_we;
  logic [PW-1:0] fb_wa, fb_ra;
  logic          fb_wd, fb_rd;
  logic          v_we;
  logic [3:0]    v_wa, v_ra;
  logic [7:0]    v_wd, v_rd;

  c8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_pmem (
    .clk_i, .we_i(pm_we), .waddr_i(pm_wa), .wdata_i(pm_wd), .raddr_i(pm_ra), .rdata_o(pm_rd)
  );
  c8_ram #(.WIDTH(1), .DEPTH(SCREEN_PIXELS)) u_fbuf (
    .clk_i, .we_i(fb_we), .waddr_i(fb_wa), .wdata_i(fb_wd), .raddr_i(fb_ra), .rdata_o(fb_rd)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd)
  );

  // decode fields
  logic [3:0]  f_x, f_y, f_n;
  logic [7:0]  f_kk;
  logic [11:0] f_nnn;
  assign f_x   = op_q[11:8];
  assign f_y   = op_q[7:4];
  assign f_n   = op_q[3:0];
  assign f_kk  = op_q[7:0];
  assign f_nnn = op_q[11:0];

  logic [11:0]    pc_nxt, pc_skip;
  logic [SPW-1:0] sp_inc, sp_dec;
  logic [8:0]     sum9;
  logic [16:0]    isum;
  logic [15:0]    i_idx, i_row, i_step;
  logic [7:0]     yr;
  logic [15:0]    pfull;
  logic [PW-1:0]  ppos;
  logic           key_any;
  logic [3:0]     key_hi;
  logic [7:0]     rem100, tens, dig;
  logic [1:0]     hund;
  logic [11:0]    tens_mul;
  logic           last_col, last_row, hit_new;
  logic [7:0]     st_next, dt_next;

  assign pc_nxt  = pc_q + 12'd2;
  assign pc_skip = pc_q + 12'd4;
  assign sp_inc  = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec  = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
  assign isum    = {1'b0, i_q} + {9'd0, vx_q};
  assign i_idx   = i_q + {12'd0, cnt_q[3:0]};
  assign i_row   = i_q + {12'd0, row_q};
  assign i_step  = i_q + {12'd0, f_x} + 16'd1;
  assign yr      = vy_q + {4'd0, row_q};
  assign pfull   = {2'd0, yr, 6'd0} + {8'd0, vx_q} + {13'd0, col_q};
  assign ppos    = pfull[PW-1:0];
  assign last_col = (col_q == 3'd7);
  assign last_row = (row_q == f_n - 4'd1);

  // BCD digits: hundreds by compare, tens by reciprocal multiply (x*205>>11)
  always_comb begin
    if (vx_q >= 8'd200) begin
      hund   = 2'd2;
      rem100 = vx_q - 8'd200;
    end else if (vx_q >= 8'd100) begin
      hund   = 2'd1;
      rem100 = vx_q - 8'd100;
    end else begin
      hund   = 2'd0;
      rem100 = vx_q;
    end
  end
  logic [15:0] tprod;
  assign tprod    = {8'd0, rem100} * 16'd205;
  assign tens     = {3'd0, tprod[15:11]};
  assign tens_mul = {4'd0, tens} * 12'd10;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    dig = {6'd0, hund};
      2'd1:    dig = tens;
      default: dig = rem100 - tens_mul[7:0];
    endcase
  end

  always_comb begin
    key_any = 1'b0;
    key_hi  = '0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) begin
        key_any = 1'b1;
        key_hi  = 4'(k);
      end
    end
  end

  assign dt_next = (tick_q && dt_q != 8'd0) ? dt_q - 8'd1 : dt_q;
  assign st_next = (tick_q && st_q != 8'd0) ? st_q - 8'd1 : st_q;
  assign hit_new = hit_q | ((state_q == S_DRWR) & fb_rd);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pc_d     = pc_q;
    ophi_d   = ophi_q;
    op_d     = op_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    i_d      = i_q;
    sp_d     = sp_q;
    stack_d  = stack_q;
    keys_d   = keys_q;
    dt_d     = dt_q;
    st_d     = st_q;
    dirty_d  = dirty_q;
    rnd_d    = rnd_q;
    bad_d    = bad_q;
    wait_d   = wait_q;
    pix_d    = pix_q;
    tick_d   = tick_q;
    flag_d   = flag_q;
    hit_d    = hit_q;
    bits_d   = bits_q;
    row_d    = row_q;
    col_d    = col_q;
    ovalid_d = ovalid_q & ~out_o.ready;
    odata_d  = odata_q;
    pm_we = 1'b0; pm_wa = '0; pm_wd = '0; pm_ra = '0;
    fb_we = 1'b0; fb_wa = '0; fb_wd = 1'b0; fb_ra = '0;
    v_we  = 1'b0; v_wa  = '0; v_wd  = '0;  v_ra  = '0;

    case (state_q)
      S_CLR: begin
        pm_we = 1'b1;
        pm_wa = cnt_q;
        pm_wd = (cnt_q < AW'(FONT_BYTES)) ? FONT[cnt_q[6:0]] : 8'd0;
        fb_we = (cnt_q < AW'(SCREEN_PIXELS));
        fb_wa = cnt_q[PW-1:0];
        v_we  = (cnt_q < AW'(16));
        v_wa  = cnt_q[3:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(MEMORY_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        bad_d  = 1'b0;
        wait_d = 1'b0;
        pix_d  = 1'b0;
        tick_d = 1'b0;
        rnd_d  = in_i.data.random_byte;
        fb_ra  = in_i.data.pixel_index[PW-1:0];
        if (in_i.valid) begin
          case (in_i.data.action)
            ACT_EXEC:  state_d = S_FETCHHI;
            ACT_KEY: begin
              keys_d[in_i.data.key_index] = in_i.data.key_pressed;
              state_d = S_DONE;
            end
            ACT_WRITE: begin
              pm_we   = 1'b1;
              pm_wa   = in_i.data.load_address[AW-1:0];
              pm_wd   = in_i.data.load_byte;
              state_d = S_DONE;
            end
            default:   state_d = S_PIX;
          endcase
        end
      end
      S_PIX: begin
        pix_d   = fb_rd;
        state_d = S_DONE;
      end
      S_FETCHHI: begin
        pm_ra   = pc_q[AW-1:0];
        state_d = S_FETCHLO;
      end
      S_FETCHLO: begin
        pm_ra   = pc_nxt[AW-1:0] - AW'(1);
        ophi_d  = pm_rd;
        state_d = S_DEC;
      end
      S_DEC: begin
        op_d    = {ophi_q, pm_rd};
        v_ra    = ophi_q[3:0];
        state_d = S_RDX;
      end
      S_RDX: begin
        vx_d    = v_rd;
        // JP V0 needs V0 in place of Vy
        v_ra    = (op_q[15:12] == GRP_JPV0) ? 4'd0 : f_y;
        state_d = S_RDY;
      end
      S_RDY: begin
        vy_d    = v_rd;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        tick_d  = 1'b1;
        pc_d    = pc_nxt;
        state_d = S_DONE;
        v_wa    = f_x;
        cnt_d   = '0;
        case (op_q[15:12])
          GRP_SYS: begin
            if (op_q == OP_CLS) begin
              dirty_d = 1'b1;
              state_d = S_FBCLR;
            end else if (op_q == OP_RET) begin
              sp_d = sp_dec;
              pc_d = stack_q[sp_dec] + 12'd2;
            end else begin
              bad_d = 1'b1;
              pc_d  = pc_q;
            end
          end
          GRP_JP:   pc_d = f_nnn;
          GRP_CALL: begin
            stack_d[sp_q] = pc_q;
            sp_d = sp_inc;
            pc_d = f_nnn;
          end
          GRP_SE:   if (vx_q == f_kk) pc_d = pc_skip;
          GRP_SNE:  if (vx_q != f_kk) pc_d = pc_skip;
          GRP_SER:  if (vx_q == vy_q) pc_d = pc_skip;
          GRP_SNER: if (vx_q != vy_q) pc_d = pc_skip;
          GRP_LD: begin
            v_we = 1'b1;
            v_wd = f_kk;
          end
          GRP_ADD: begin
            v_we = 1'b1;
            v_wd = vx_q + f_kk;
          end
          GRP_ALU: begin
            v_we = 1'b1;
            case (f_n)
              ALU_MOV: v_wd = vy_q;
              ALU_OR:  v_wd = vx_q | vy_q;
              ALU_AND: v_wd = vx_q & vy_q;
              ALU_XOR: v_wd = vx_q ^ vy_q;
              ALU_ADD: begin
                v_wd = sum9[7:0]; flag_d = sum9[8]; state_d = S_FLAG;
              end
              ALU_SUB: begin
                v_wd = vx_q - vy_q; flag_d = (vy_q <= vx_q); state_d = S_FLAG;
              end
              ALU_SHR: begin
                v_wd = {1'b0, vx_q[7:1]}; flag_d = vx_q[0]; state_d = S_FLAG;
              end
              ALU_SBN: begin
                v_wd = vy_q - vx_q; flag_d = (vx_q <= vy_q); state_d = S_FLAG;
              end
              ALU_SHL: begin
                v_wd = {vx_q[6:0], 1'b0}; flag_d = vx_q[7]; state_d = S_FLAG;
              end
              default: begin
                v_we  = 1'b0;
                bad_d = 1'b1;
                pc_d  = pc_q;
              end
            endcase
          end
          GRP_LDI:  i_d = {4'd0, f_nnn};
          GRP_JPV0: pc_d = f_nnn + {4'd0, vy_q};
          GRP_RND: begin
            v_we = 1'b1;
            v_wd = rnd_q & f_kk;
          end
          GRP_DRW: begin
            dirty_d = 1'b1;
            hit_d   = 1'b0;
            row_d   = '0;
            flag_d  = 1'b0;
            state_d = (f_n == 4'd0) ? S_FLAG : S_DRMEM;
          end
          GRP_KEY: begin
            if (f_kk == KEY_SKP) begin
              if (keys_q[vx_q[3:0]]) pc_d = pc_skip;
            end else if (f_kk == KEY_SKNP) begin
              if (!keys_q[vx_q[3:0]]) pc_d = pc_skip;
            end else begin
              bad_d = 1'b1;
              pc_d  = pc_q;
            end
          end
          default: begin
            case (f_kk)
              F_GETDT: begin
                v_we = 1'b1;
                v_wd = dt_q;
              end
              F_WKEY: begin
                if (key_any) begin
                  v_we = 1'b1;
                  v_wd = {4'd0, key_hi};
                end else begin
                  // no key: nothing moves, not even the timers
                  wait_d = 1'b1;
                  tick_d = 1'b0;
                  pc_d   = pc_q;
                end
              end
              F_SETDT: dt_d = vx_q;
              F_SETST: st_d = vx_q;
              F_ADDI: begin
                i_d     = isum[15:0];
                flag_d  = (isum[16:12] != 5'd0);
                state_d = S_FLAG;
              end
              F_FONT:  i_d = {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
              F_BCD:   state_d = S_BCD;
              F_STORE: state_d = S_STRD;
              F_LOAD:  state_d = S_LDRD;
              default: begin
                bad_d = 1'b1;
                pc_d  = pc_q;
              end
            endcase
          end
        endcase
      end
      S_FLAG: begin
        v_we    = 1'b1;
        v_wa    = REG_FLAG;
        v_wd    = {7'd0, flag_q};
        state_d = S_DONE;
      end
      S_FBCLR: begin
        fb_we = 1'b1;
        fb_wa = cnt_q[PW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(SCREEN_PIXELS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_BCD: begin
        pm_we = 1'b1;
        pm_wa = i_idx[AW-1:0];
        pm_wd = dig;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_STRD: begin
        v_ra    = cnt_q[3:0];
        state_d = S_STWR;
      end
      S_STWR: begin
        pm_we = 1'b1;
        pm_wa = i_idx[AW-1:0];
        pm_wd = v_rd;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[3:0] == f_x) begin
          i_d     = i_step;
          state_d = S_DONE;
        end else begin
          state_d = S_STRD;
        end
      end
      S_LDRD: begin
        pm_ra   = i_idx[AW-1:0];
        state_d = S_LDWR;
      end
      S_LDWR: begin
        v_we  = 1'b1;
        v_wa  = cnt_q[3:0];
        v_wd  = pm_rd;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[3:0] == f_x) begin
          i_d     = i_step;
          state_d = S_DONE;
        end else begin
          state_d = S_LDRD;
        end
      end
      S_DRMEM: begin
        pm_ra   = i_row[AW-1:0];
        state_d = S_DRBYTE;
      end
      S_DRBYTE: begin
        bits_d  = pm_rd;
        col_d   = '0;
        state_d = S_DRRD;
      end
      S_DRRD, S_DRWR: begin
        fb_ra = ppos;
        if (state_q == S_DRRD && bits_q[3'd7 - col_q]) begin
          state_d = S_DRWR;
        end else begin
          if (state_q == S_DRWR) begin
            fb_we = 1'b1;
            fb_wa = ppos;
            fb_wd = ~fb_rd;
            hit_d = hit_new;
          end
          if (!last_col) begin
            col_d   = col_q + 3'd1;
            state_d = S_DRRD;
          end else if (last_row) begin
            flag_d  = hit_new;
            state_d = S_FLAG;
          end else begin
            row_d   = row_q + 4'd1;
            state_d = S_DRMEM;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          dt_d     = dt_next;
          st_d     = st_next;
          ovalid_d = 1'b1;
          odata_d.pc_value       = pc_q;
          odata_d.current_opcode = op_q;
          odata_d.draw_pending   = dirty_q;
          odata_d.sound_on       = (st_next != 8'd0);
          odata_d.pixel_value    = pix_q;
          odata_d.bad_opcode     = bad_q;
          odata_d.waiting_key    = wait_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      pc_q     <= START_PC;
      op_q     <= '0;
      i_q      <= '0;
      sp_q     <= '0;
      for (int s = 0; s < STACK_DEPTH; s++) stack_q[s] <= '0;
      keys_q   <= '0;
      dt_q     <= '0;
      st_q     <= '0;
      dirty_q  <= 1'b1;
      bad_q    <= 1'b0;
      wait_q   <= 1'b0;
      pix_q    <= 1'b0;
      tick_q   <= 1'b0;
      flag_q   <= 1'b0;
      hit_q    <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pc_q     <= pc_d;
      op_q     <= op_d;
      i_q      <= i_d;
      sp_q     <= sp_d;
      stack_q  <= stack_d;
      keys_q   <= keys_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      dirty_q  <= dirty_d;
      bad_q    <= bad_d;
      wait_q   <= wait_d;
      pix_q    <= pix_d;
      tick_q   <= tick_d;
      flag_q   <= flag_d;
      hit_q    <= hit_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ophi_q  <= ophi_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    rnd_q   <= rnd_d;
    bits_q  <= bits_d;
    odata_q <= odata_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_DONE)) else $error("result without finish");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH - 1)) else $error("stack pointer beyond depth");

  a_draw_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRRD) |-> (row_q < f_n)) else $error("draw row past sprite height");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import c8_pkg::*;

  logic clk_i;
  logic rst_ni;

  c8_in_if  in_ch ();
  c8_out_if out_ch ();

  chip8_instruction_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the machine
  logic [7:0]  mem_q [MEM_BYTES];
  logic [7:0]  vreg_q [16];
  logic [15:0] ireg_q;
  logic [11:0] pc_q;
  logic [11:0] stack_q [STACK_DEPTH];
  logic [3:0]  sp_q;
  logic        fb_q [SCR_PIXELS];
  logic        keys_q [16];
  logic [7:0]  delay_q;
  logic [7:0]  sound_q;
  logic        dirty_q;
  logic [15:0] word_q;

  c8_out_t expected_results[$];
  int      fail_count;
  int      result_count;
  int      exec_count;
  int      draw_count;
  int      wait_count;
  int      bad_count;

  function automatic void machine_reset();
    for (int a = 0; a < MEM_BYTES; a++) mem_q[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
    for (int a = 0; a < 16; a++) begin
      vreg_q[a] = '0;
      keys_q[a] = 1'b0;
    end
    for (int a = 0; a < STACK_DEPTH; a++) stack_q[a] = '0;
    for (int a = 0; a < SCR_PIXELS; a++) fb_q[a] = 1'b0;
    ireg_q  = '0;
    pc_q    = START_PC;
    sp_q    = '0;
    delay_q = '0;
    sound_q = '0;
    dirty_q = 1'b1;
    word_q  = '0;
  endfunction

  function automatic c8_out_t machine_step(input c8_in_t d);
    c8_out_t     r;
    logic [15:0] w;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, bits;
    logic [11:0] nnn;
    logic [12:0] nxt;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic        bad, hit;
    int          found;
    int unsigned p;
    r   = '0;
    bad = 1'b0;
    case (action_e'(d.action))
      ACT_KEY:   keys_q[d.key_index] = d.key_pressed;
      ACT_WRITE: mem_q[d.load_address] = d.load_byte;
      ACT_PIXEL: r.pixel_value = fb_q[d.pixel_index];
      default: begin
        w      = {mem_q[pc_q], mem_q[12'(pc_q + 12'd1)]};
        word_q = w;
        x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
        vx = vreg_q[x]; vy = vreg_q[y];
        nxt = 13'(pc_q) + 13'd2;
        found = -1;
        case (w[15:12])
          GRP_SYS: begin
            if (w == OP_CLS) begin
              for (int a = 0; a < SCR_PIXELS; a++) fb_q[a] = 1'b0;
              dirty_q = 1'b1;
            end else if (w == OP_RET) begin
              sp_q = sp_q - 4'd1;
              nxt  = 13'(stack_q[sp_q]) + 13'd2;
            end else bad = 1'b1;
          end
          GRP_JP:   nxt = 13'(nnn);
          GRP_CALL: begin
            stack_q[sp_q] = pc_q;
            sp_q = sp_q + 4'd1;
            nxt  = 13'(nnn);
          end
          GRP_SE:   if (vx == kk) nxt += 13'd2;
          GRP_SNE:  if (vx != kk) nxt += 13'd2;
          GRP_SER:  if (vx == vy) nxt += 13'd2;
          GRP_LD:   vreg_q[x] = kk;
          GRP_ADD:  vreg_q[x] = vx + kk;
          GRP_ALU: begin
            case (n)
              ALU_MOV: vreg_q[x] = vy;
              ALU_OR:  vreg_q[x] = vx | vy;
              ALU_AND: vreg_q[x] = vx & vy;
              ALU_XOR: vreg_q[x] = vx ^ vy;
              ALU_ADD: begin
                sum9 = 9'(vx) + 9'(vy);
                vreg_q[x] = sum9[7:0];
                vreg_q[REG_FLAG] = {7'd0, sum9[8]};
              end
              ALU_SUB: begin
                vreg_q[x] = vx - vy;
                vreg_q[REG_FLAG] = {7'd0, vy <= vx};
              end
              ALU_SHR: begin
                vreg_q[x] = vx >> 1;
                vreg_q[REG_FLAG] = {7'd0, vx[0]};
              end
              ALU_SBN: begin
                vreg_q[x] = vy - vx;
                vreg_q[REG_FLAG] = {7'd0, vx <= vy};
              end
              ALU_SHL: begin
                vreg_q[x] = vx << 1;
                vreg_q[REG_FLAG] = {7'd0, vx[7]};
              end
              default: bad = 1'b1;
            endcase
          end
          GRP_SNER: if (vx != vy) nxt += 13'd2;
          GRP_LDI:  ireg_q = 16'(nnn);
          GRP_JPV0: nxt = 13'(nnn) + 13'(vreg_q[0]);
          GRP_RND:  vreg_q[x] = d.random_byte & kk;
          GRP_DRW: begin
            hit = 1'b0;
            for (int row = 0; row < n; row++) begin
              bits = mem_q[12'(ireg_q + 16'(row))];
              for (int col = 0; col < 8; col++) begin
                if (bits[7-col]) begin
                  p = (int'(vx) + col + (int'(vy) + row) * SCREEN_COLS) % SCR_PIXELS;
                  if (fb_q[p]) hit = 1'b1;
                  fb_q[p] = ~fb_q[p];
                end
              end
            end
            vreg_q[REG_FLAG] = {7'd0, hit};
            dirty_q = 1'b1;
          end
          GRP_KEY: begin
            if (kk == KEY_SKP) begin
              if (keys_q[vx[3:0]]) nxt += 13'd2;
            end else if (kk == KEY_SKNP) begin
              if (!keys_q[vx[3:0]]) nxt += 13'd2;
            end else bad = 1'b1;
          end
          default: begin
            case (kk)
              F_GETDT: vreg_q[x] = delay_q;
              F_WKEY: begin
                for (int k = 0; k < 16; k++) if (keys_q[k]) found = k;
                if (found >= 0) vreg_q[x] = 8'(found);
              end
              F_SETDT: delay_q = vx;
              F_SETST: sound_q = vx;
              F_ADDI: begin
                sum17 = 17'(ireg_q) + 17'(vx);
                ireg_q = sum17[15:0];
                vreg_q[REG_FLAG] = {7'd0, sum17 > 17'h0FFF};
              end
              F_FONT: ireg_q = 16'(vx) * 16'd5;
              F_BCD: begin
                mem_q[12'(ireg_q)]          = vx / 100;
                mem_q[12'(ireg_q + 16'd1)]  = (vx / 10) % 10;
                mem_q[12'(ireg_q + 16'd2)]  = vx % 10;
              end
              F_STORE: begin
                for (int k = 0; k <= x; k++) mem_q[12'(ireg_q + 16'(k))] = vreg_q[k];
                ireg_q = ireg_q + 16'(x) + 16'd1;
              end
              F_LOAD: begin
                for (int k = 0; k <= x; k++) vreg_q[k] = mem_q[12'(ireg_q + 16'(k))];
                ireg_q = ireg_q + 16'(x) + 16'd1;
              end
              default: bad = 1'b1;
            endcase
          end
        endcase
        if (w[15:12] == GRP_MISC && kk == F_WKEY && found < 0) begin
          // waiting for a key: nothing moves, not even the timers
          r.waiting_key = 1'b1;
          wait_count++;
        end else begin
          if (!bad) pc_q = nxt[11:0];
          if (delay_q != 0) delay_q--;
          if (sound_q != 0) sound_q--;
        end
        r.bad_opcode = bad;
        bad_count += int'(bad);
        draw_count += int'(w[15:12] == GRP_DRW);
        exec_count++;
      end
    endcase
    r.pc_value       = pc_q;
    r.current_opcode = word_q;
    r.draw_pending   = dirty_q;
    r.sound_on       = (sound_q != 0);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // sender
  int burst_left;

  task automatic send_item(input c8_in_t d);
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_results.push_back(machine_step(d));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else burst_left--;
  endtask

  function automatic c8_in_t noise_item(input action_e act);
    c8_in_t d;
    d = c8_in_t'({$urandom, $urandom});
    d.action = act;
    return d;
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    int          pick;
    w = 16'($urandom);
    pick = $urandom_range(0, 9);
    case (w[15:12])
      GRP_SYS: begin
        if (pick == 0)     w = OP_CLS;
        else if (pick < 6) w = OP_RET;
      end
      GRP_JP, GRP_CALL, GRP_JPV0: if (pick == 0) w[11:0] = 12'hFFE + 12'($urandom_range(0, 1));
      GRP_KEY: begin
        if (pick < 4)      w[7:0] = KEY_SKP;
        else if (pick < 8) w[7:0] = KEY_SKNP;
      end
      GRP_MISC: begin
        case ($urandom_range(0, 9))
          0: w[7:0] = F_GETDT;
          1: w[7:0] = F_WKEY;
          2: w[7:0] = F_SETDT;
          3: w[7:0] = F_SETST;
          4: w[7:0] = F_ADDI;
          5: w[7:0] = F_FONT;
          6: w[7:0] = F_BCD;
          7: w[7:0] = F_STORE;
          8: w[7:0] = F_LOAD;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  typedef struct {
    action_e     act;
    logic [11:0] addr_or_pix;
    logic [7:0]  value;
    logic        known;
    c8_out_t     result;
  } directed_row_t;

  localparam c8_out_t IDLE_OUT = '{pc_value: START_PC, current_opcode: 16'h0000,
                                   draw_pending: 1'b1, default: 1'b0};

  directed_row_t directed_rows[] = '{
    '{ACT_PIXEL, 12'd0,    8'h00, 1'b1, IDLE_OUT},
    '{ACT_PIXEL, 12'd2047, 8'h00, 1'b1, IDLE_OUT},
    // blank memory at the start address is an unknown word
    '{ACT_EXEC,  12'd0,    8'h00, 1'b1, '{START_PC, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{ACT_WRITE, 12'h200,  8'hF0, 1'b1, IDLE_OUT},
    '{ACT_WRITE, 12'h201,  8'h0A, 1'b1, IDLE_OUT},
    // wait for key with nothing pressed
    '{ACT_EXEC,  12'd0,    8'h00, 1'b1, '{START_PC, 16'hF00A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ACT_KEY,   12'd15,   8'h01, 1'b0, '0},
    '{ACT_KEY,   12'd3,    8'h01, 1'b0, '0},
    '{ACT_EXEC,  12'd0,    8'h00, 1'b0, '0},
    '{ACT_WRITE, 12'hFFF,  8'hFF, 1'b0, '0},
    '{ACT_WRITE, 12'h000,  8'h12, 1'b0, '0},
    '{ACT_KEY,   12'd15,   8'h00, 1'b0, '0},
    '{ACT_WRITE, 12'h202,  8'h6F, 1'b0, '0},
    '{ACT_WRITE, 12'h203,  8'hFF, 1'b0, '0},
    '{ACT_EXEC,  12'd0,    8'h00, 1'b0, '0},
    // add with x = F: the carry flag overwrites the sum
    '{ACT_WRITE, 12'h204,  8'h8F, 1'b0, '0},
    '{ACT_WRITE, 12'h205,  8'hF4, 1'b0, '0},
    '{ACT_EXEC,  12'd0,    8'h00, 1'b0, '0},
    // return on an empty stack wraps the pointer
    '{ACT_WRITE, 12'h206,  8'h00, 1'b0, '0},
    '{ACT_WRITE, 12'h207,  8'hEE, 1'b0, '0},
    '{ACT_EXEC,  12'd0,    8'h00, 1'b0, '0},
    '{ACT_PIXEL, 12'd1,    8'h00, 1'b0, '0}
  };

  logic        known_q[$];
  c8_out_t     typed_q[$];

  initial begin
    c8_in_t      d;
    int          sent;
    int          pick;
    logic [15:0] w;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    fail_count = 0; result_count = 0; exec_count = 0;
    draw_count = 0; wait_count = 0; bad_count = 0;
    burst_left = 0;
    machine_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      d = '0;
      d.action       = directed_rows[i].act;
      d.key_index    = directed_rows[i].addr_or_pix[3:0];
      d.key_pressed  = directed_rows[i].value[0];
      d.load_address = directed_rows[i].addr_or_pix;
      d.load_byte    = directed_rows[i].value;
      d.pixel_index  = directed_rows[i].addr_or_pix[10:0];
      known_q.push_back(directed_rows[i].known);
      typed_q.push_back(directed_rows[i].result);
      send_item(d);
    end

    sent = 0;
    while (sent < 500) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // place a random instruction at the current PC, then run it
        w = random_word();
        d = noise_item(ACT_WRITE);
        d.load_address = pc_q;
        d.load_byte    = w[15:8];
        send_item(d);
        d = noise_item(ACT_WRITE);
        d.load_address = pc_q + 12'd1;
        d.load_byte    = w[7:0];
        send_item(d);
        send_item(noise_item(ACT_EXEC));
        sent += 3;
      end else begin
        if (pick < 75)      d = noise_item(ACT_KEY);
        else if (pick < 90) d = noise_item(ACT_PIXEL);
        else if (pick < 95) d = noise_item(ACT_WRITE);
        else                d = noise_item(ACT_EXEC);
        send_item(d);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d results: %0d instructions (%0d draws, %0d key waits, %0d unknown).",
             result_count, exec_count, draw_count, wait_count, bad_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // receiver and checker
  int unsigned cycle_count;

  initial out_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    c8_out_t got, exp_r;
    logic    typed;
    cycle_count <= cycle_count + 1;
    // alternate stretches of full rate with random stalling
    out_ch.ready <= cycle_count[7] ? 1'b1 : ($urandom_range(0, 3) != 0);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %p", got);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        typed = 1'b0;
        if (known_q.size() != 0) begin
          typed = known_q.pop_front();
          if (typed) exp_r = typed_q[0];
          void'(typed_q.pop_front());
        end
        if (got.pc_value !== exp_r.pc_value) begin
          $error("pc_value exp %h got %h", exp_r.pc_value, got.pc_value); fail_count++;
        end
        if (got.current_opcode !== exp_r.current_opcode) begin
          $error("current_opcode exp %h got %h", exp_r.current_opcode, got.current_opcode);
          fail_count++;
        end
        if (got.draw_pending !== exp_r.draw_pending) begin
          $error("draw_pending exp %b got %b", exp_r.draw_pending, got.draw_pending);
          fail_count++;
        end
        if (got.sound_on !== exp_r.sound_on) begin
          $error("sound_on exp %b got %b", exp_r.sound_on, got.sound_on); fail_count++;
        end
        if (got.pixel_value !== exp_r.pixel_value) begin
          $error("pixel_value exp %b got %b", exp_r.pixel_value, got.pixel_value);
          fail_count++;
        end
        if (got.bad_opcode !== exp_r.bad_opcode) begin
          $error("bad_opcode exp %b got %b", exp_r.bad_opcode, got.bad_opcode); fail_count++;
        end
        if (got.waiting_key !== exp_r.waiting_key) begin
          $error("waiting_key exp %b got %b", exp_r.waiting_key, got.waiting_key);
          fail_count++;
        end
      end
    end
  end

  initial cycle_count = 0;

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/c8_pkg.sv
rtl/c8_if.sv
rtl/c8_ram.sv
rtl/chip8_instruction_core.sv
dv/testbench.sv
